// File: rtl/core/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

  localparam int WORD_W      = 16;
  localparam int ADDR_IN_W   = 8;
  localparam int SAMPLE_W    = 10;
  localparam int ACC_W       = 21;
  localparam int TICK_SHIFT  = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [ACC_W-1:0]  SAMPLE_RATE   = ACC_W'(44100);
  localparam logic [WORD_W-1:0] END_RESET     = 16'h8000;
  localparam logic [WORD_W-1:0] REPEAT_RESET  = 16'h8001;
  localparam logic [WORD_W-1:0] VOL_RESET     = 16'h8000;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_AUDIO = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_ON   = 2'd2
  } note_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_MARKER    = 2'd0,
    REG_REPEAT_MARKER = 2'd1,
    REG_VOLUME_MASK   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_ACCUM,
    ST_COUNT,
    ST_RD_F,
    ST_EV_F,
    ST_RD_R,
    ST_EV_R,
    ST_RD_D,
    ST_EV_D
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/tsp_alu.sv
`default_nettype none

module tsp_alu
  import tsp_pkg::*;
(
  input  wire alu_op_t            op,
  input  wire logic [ACC_W-1:0]   a,
  input  wire logic [ACC_W-1:0]   b,
  output logic      [ACC_W-1:0]   res,
  output logic                    borrow
);

  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] b_eff;

  assign b_eff  = (op == ALU_SUB) ? ~b : b;
  assign sum    = {1'b0, a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, (op == ALU_SUB)};
  assign res    = sum[ACC_W-1:0];
  assign borrow = (op == ALU_SUB) && !sum[ACC_W];

endmodule

`default_nettype wire

// File: rtl/core/tone_sequence_player_core.sv
// Tone sequencer. Word writes fill a store of frequency/duration pairs; a start
// request plays from an address, a stop request halts, and an audio request of
// N samples advances playback by N*1024/44100 ticks of 1/1024 s. Every request
// gives exactly one result, shown for one cycle with out_valid high in the first
// cycle in which busy is low again; the receiver cannot stall it, and a new
// request may be issued in that same cycle. Busy time is set by a small sequencer
// around one shared adder/subtractor and one store read port: a request first
// reduces its address modulo STORE_DEPTH by repeated subtraction (one subtract
// per cycle), except audio requests; a word write or stop then completes; a start
// then fetches a tone: it reads and checks the frequency word, stops on the end
// marker, jumps back to the start address after a repeat marker and reads the
// frequency there, then reads the duration. An audio request ends in its first
// step when no tone counts down; else it adds N*1024, then counts off one tick per
// subtract of 44100; if the tone ends, the final compare gives way to a fetch.
`default_nettype none

module tone_sequence_player_core
  import tsp_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  start,
  output logic                        busy,
  input  wire  logic [1:0]            in_action,
  input  wire  logic [ADDR_IN_W-1:0]  in_address,
  input  wire  logic [WORD_W-1:0]     in_word,
  input  wire  logic [SAMPLE_W-1:0]   in_sample_count,
  input  wire  logic                  in_sound_enabled,
  output logic                        out_valid,
  output logic                        out_playing,
  output logic [1:0]                  out_note_command,
  output logic [WORD_W-1:0]           out_note_frequency,
  output logic [WORD_W-1:0]           out_ticks_remaining,
  input  wire  logic                  cfg_we,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [WORD_W-1:0]     cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int RW = (AW + 1 > ADDR_IN_W) ? AW + 1 : ADDR_IN_W;

  // configuration
  logic [WORD_W-1:0] end_marker_r, repeat_marker_r, vol_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_marker_r    <= END_RESET;
      repeat_marker_r <= REPEAT_RESET;
      vol_mask_r      <= VOL_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_END_MARKER:    end_marker_r    <= cfg_data;
        REG_REPEAT_MARKER: repeat_marker_r <= cfg_data;
        REG_VOLUME_MASK:   vol_mask_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  state_t            state_r, state_nxt;
  logic [AW-1:0]     rp_r, rp_nxt;
  logic [AW-1:0]     start_pos_r, start_pos_nxt;
  logic              active_r, active_nxt;
  logic              playing_r, playing_nxt;
  logic [WORD_W-1:0] tick_r, tick_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  // request payload and working data
  action_t             act_r;
  logic [RW-1:0]       addr_r, addr_nxt;
  logic [WORD_W-1:0]   word_r;
  logic [SAMPLE_W-1:0] samples_r;
  logic                en_r;
  logic [WORD_W-1:0]   freq_r, freq_nxt;

  // store
  logic [WORD_W-1:0] mem [STORE_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;

  // shared unit
  alu_op_t          alu_op;
  logic [ACC_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_borrow;

  tsp_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // result
  logic              fin;
  note_cmd_t         cmd;
  logic [WORD_W-1:0] res_freq;
  logic [AW-1:0]     rp_inc;

  assign rp_inc = (rp_r == AW'(STORE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    start_pos_nxt = start_pos_r;
    active_nxt    = active_r;
    playing_nxt   = playing_r;
    tick_nxt      = tick_r;
    acc_nxt       = acc_r;
    addr_nxt      = addr_r;
    freq_nxt      = freq_r;
    mem_we        = 1'b0;
    fin           = 1'b0;
    cmd           = CMD_NONE;
    res_freq      = '0;
    alu_op        = ALU_SUB;
    alu_a         = '0;
    alu_b         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          addr_nxt  = {{(RW-ADDR_IN_W){1'b0}}, in_address};
          state_nxt = (action_t'(in_action) == ACT_AUDIO) ? ST_ACCUM : ST_REDUCE;
        end
      end

      ST_REDUCE: begin
        alu_op = ALU_SUB;
        alu_a  = {{(ACC_W-RW){1'b0}}, addr_r};
        alu_b  = ACC_W'(STORE_DEPTH);
        if (!alu_borrow) begin
          addr_nxt = alu_res[RW-1:0];
        end else begin
          case (act_r)
            ACT_WRITE: begin
              mem_we    = 1'b1;
              fin       = 1'b1;
              state_nxt = ST_IDLE;
            end
            ACT_START: begin
              start_pos_nxt = addr_r[AW-1:0];
              rp_nxt        = addr_r[AW-1:0];
              active_nxt    = 1'b1;
              state_nxt     = ST_RD_F;
            end
            default: begin
              // stop
              active_nxt    = 1'b0;
              playing_nxt   = 1'b0;
              start_pos_nxt = '0;
              tick_nxt      = '0;
              acc_nxt       = '0;
              cmd           = CMD_OFF;
              fin           = 1'b1;
              state_nxt     = ST_IDLE;
            end
          endcase
        end
      end

      ST_ACCUM: begin
        if (active_r && (tick_r != '0)) begin
          alu_op    = ALU_ADD;
          alu_a     = acc_r;
          alu_b     = ACC_W'({samples_r, {TICK_SHIFT{1'b0}}});
          acc_nxt   = alu_res;
          state_nxt = ST_COUNT;
        end else begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_COUNT: begin
        alu_op = ALU_SUB;
        alu_a  = acc_r;
        alu_b  = SAMPLE_RATE;
        if (!alu_borrow) begin
          acc_nxt  = alu_res;
          tick_nxt = tick_r - 1'b1;
          if (tick_r == WORD_W'(1)) begin
            state_nxt = ST_RD_F;
          end
        end else begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_RD_F: begin
        rp_nxt    = rp_inc;
        state_nxt = ST_EV_F;
      end

      ST_EV_F: begin
        if (rdata_r == end_marker_r) begin
          active_nxt    = 1'b0;
          playing_nxt   = 1'b0;
          start_pos_nxt = '0;
          tick_nxt      = '0;
          acc_nxt       = '0;
          cmd           = CMD_OFF;
          fin           = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (rdata_r == repeat_marker_r) begin
          playing_nxt = 1'b1;
          rp_nxt      = start_pos_r;
          state_nxt   = ST_RD_R;
        end else begin
          playing_nxt = 1'b1;
          freq_nxt    = rdata_r & ~vol_mask_r;
          state_nxt   = ST_RD_D;
        end
      end

      ST_RD_R: begin
        rp_nxt    = rp_inc;
        state_nxt = ST_EV_R;
      end

      ST_EV_R: begin
        freq_nxt  = rdata_r & ~vol_mask_r;
        state_nxt = ST_RD_D;
      end

      ST_RD_D: begin
        rp_nxt    = rp_inc;
        state_nxt = ST_EV_D;
      end

      ST_EV_D: begin
        tick_nxt = rdata_r;
        acc_nxt  = '0;
        fin      = 1'b1;
        if ((freq_r != '0) && en_r) begin
          cmd      = CMD_ON;
          res_freq = freq_r;
        end else begin
          cmd = CMD_OFF;
        end
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      start_pos_r <= '0;
      active_r    <= 1'b0;
      playing_r   <= 1'b0;
      tick_r      <= '0;
      acc_r       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      start_pos_r <= start_pos_nxt;
      active_r    <= active_nxt;
      playing_r   <= playing_nxt;
      tick_r      <= tick_nxt;
      acc_r       <= acc_nxt;
      out_valid   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    freq_r <= freq_nxt;
    if (state_r == ST_IDLE && start) begin
      act_r     <= action_t'(in_action);
      word_r    <= in_word;
      samples_r <= in_sample_count;
      en_r      <= in_sound_enabled;
    end
    if (fin) begin
      out_playing         <= playing_nxt;
      out_note_command    <= cmd;
      out_note_frequency  <= res_freq;
      out_ticks_remaining <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r[AW-1:0]] <= word_r;
    end
    rdata_r <= mem[rp_r];
  end

endmodule

`default_nettype wire

// File: rtl/core/tsp_checker.sv
`default_nettype none

module tsp_checker
  import tsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic                  out_playing,
  input wire logic [1:0]            out_note_command,
  input wire logic [WORD_W-1:0]     out_note_frequency,
  input wire logic [WORD_W-1:0]     out_ticks_remaining
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_freq_only_on_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_note_command != CMD_ON)) |-> (out_note_frequency == '0))
    else $error("frequency given without note-on");

  a_note_on_playing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_note_command == CMD_ON)) |-> out_playing)
    else $error("note-on while not playing");

  a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_playing) |-> (out_ticks_remaining == '0))
    else $error("ticks left while not playing");

endmodule

bind tone_sequence_player_core tsp_checker u_tsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_playing         (out_playing),
  .out_note_command    (out_note_command),
  .out_note_frequency  (out_note_frequency),
  .out_ticks_remaining (out_ticks_remaining)
);

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb
  import tsp_pkg::*;
;

  typedef struct {
    action_t               act;
    logic [ADDR_IN_W-1:0]  addr;
    logic [WORD_W-1:0]     word;
    logic [SAMPLE_W-1:0]   samples;
    logic                  snd;
  } player_req_t;

  typedef struct {
    logic              playing;
    note_cmd_t         cmd;
    logic [WORD_W-1:0] freq;
    logic [WORD_W-1:0] ticks;
  } note_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_action;
  logic [ADDR_IN_W-1:0] in_address;
  logic [WORD_W-1:0]    in_word;
  logic [SAMPLE_W-1:0]  in_sample_count;
  logic                 in_sound_enabled;
  logic                 out_valid;
  logic                 out_playing;
  logic [1:0]           out_note_command;
  logic [WORD_W-1:0]    out_note_frequency;
  logic [WORD_W-1:0]    out_ticks_remaining;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  tone_sequence_player_core DUT (.*);

  // player state
  logic [WORD_W-1:0]    tone_store [256];
  logic [ADDR_IN_W-1:0] rd_pos;
  logic [ADDR_IN_W-1:0] seq_head;
  logic                 seq_on;
  logic                 is_playing;
  logic [WORD_W-1:0]    ticks_left;
  logic [ACC_W-1:0]     sample_acc;
  logic [WORD_W-1:0]    end_word;
  logic [WORD_W-1:0]    repeat_word;
  logic [WORD_W-1:0]    vol_mask;

  player_req_t  player_requests [$];
  note_report_t note_reports [$];
  logic         req_taken;
  int           send_idle_pct;
  int           fault_count;

  function automatic logic [WORD_W-1:0] pull_word();
    logic [WORD_W-1:0] w;
    w = tone_store[rd_pos];
    rd_pos = rd_pos + 1'b1;
    return w;
  endfunction

  function automatic void halt_player();
    seq_on = 1'b0;
    is_playing = 1'b0;
    seq_head = '0;
    ticks_left = '0;
    sample_acc = '0;
  endfunction

  function automatic void fetch_tone(input logic snd, inout note_report_t rep);
    logic [WORD_W-1:0] f;
    f = pull_word();
    if (f == end_word) begin
      halt_player();
      rep.cmd = CMD_OFF;
    end else begin
      is_playing = 1'b1;
      if (f == repeat_word) begin
        rd_pos = seq_head;
        f = pull_word();
      end
      f = f & ~vol_mask;
      ticks_left = pull_word();
      sample_acc = '0;
      if (f != '0 && snd) begin
        rep.cmd = CMD_ON;
        rep.freq = f;
      end else begin
        rep.cmd = CMD_OFF;
      end
    end
  endfunction

  function automatic note_report_t advance_player(player_req_t q);
    note_report_t rep;
    logic         counted_out;
    rep.cmd = CMD_NONE;
    rep.freq = '0;
    case (q.act)
      ACT_WRITE: tone_store[q.addr] = q.word;
      ACT_START: begin
        seq_head = q.addr;
        rd_pos = q.addr;
        seq_on = 1'b1;
        fetch_tone(q.snd, rep);
      end
      ACT_STOP: begin
        halt_player();
        rep.cmd = CMD_OFF;
      end
      ACT_AUDIO: begin
        if (seq_on && ticks_left != '0) begin
          sample_acc = sample_acc + (ACC_W'(q.samples) << TICK_SHIFT);
          counted_out = 1'b0;
          while (!counted_out && sample_acc >= SAMPLE_RATE) begin
            sample_acc = sample_acc - SAMPLE_RATE;
            ticks_left = ticks_left - 1'b1;
            if (ticks_left == '0) begin
              fetch_tone(q.snd, rep);
              counted_out = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    rep.playing = is_playing;
    rep.ticks = ticks_left;
    return rep;
  endfunction

  function automatic void push_req(action_t act, logic [ADDR_IN_W-1:0] addr,
                                   logic [WORD_W-1:0] word, logic [SAMPLE_W-1:0] samples,
                                   logic snd);
    player_req_t r;
    r.act = act;
    r.addr = addr;
    r.word = word;
    r.samples = samples;
    r.snd = snd;
    player_requests.push_back(r);
  endfunction

  function automatic logic [WORD_W-1:0] pick_freq();
    logic [WORD_W-1:0] f;
    case ($urandom_range(9))
      0: f = '0;
      1: f = WORD_W'($urandom);
      default: f = WORD_W'($urandom_range(20000, 20)) |
                   ($urandom_range(2) == 0 ? VOL_RESET : '0);
    endcase
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] pick_duration();
    int unsigned r;
    logic [WORD_W-1:0] d;
    r = $urandom_range(99);
    if (r < 4) d = '0;
    else if (r < 10) d = WORD_W'($urandom_range(300, 41));
    else d = WORD_W'($urandom_range(40, 1));
    return d;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (player_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        in_action <= player_requests[0].act;
        in_address <= player_requests[0].addr;
        in_word <= player_requests[0].word;
        in_sample_count <= player_requests[0].samples;
        in_sound_enabled <= player_requests[0].snd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    note_report_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (note_reports.size() == 0) begin
          if (fault_count < 10)
            $display("unrequested result: playing %0d cmd %0d freq %0d ticks %0d",
                     out_playing, out_note_command, out_note_frequency, out_ticks_remaining);
          fault_count = fault_count + 1;
        end else begin
          want = note_reports.pop_front();
          if (out_playing !== want.playing || out_note_command !== want.cmd ||
              out_note_frequency !== want.freq || out_ticks_remaining !== want.ticks) begin
            if (fault_count < 10)
              $display("mismatch got/want: play %0d/%0d cmd %0d/%0d freq %0d/%0d tk %0d/%0d",
                       out_playing, want.playing, out_note_command, want.cmd,
                       out_note_frequency, want.freq, out_ticks_remaining, want.ticks);
            fault_count = fault_count + 1;
          end
        end
      end
      if (start && !busy)
        note_reports.push_back(advance_player(player_requests.pop_front()));
    end
    req_taken <= rst_n && start && !busy;
  end

  initial begin
    logic [WORD_W-1:0]    cfg_vals [3];
    logic [ADDR_IN_W-1:0] heads [$];
    logic [ADDR_IN_W-1:0] wp;
    logic [WORD_W-1:0]    w;
    logic                 snd;
    int                   phase;
    int                   seg;
    int                   tones;
    int                   k;
    int                   n;
    int unsigned          r;

    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_WRITE;
    in_address = '0;
    in_word = '0;
    in_sample_count = '0;
    in_sound_enabled = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_END_MARKER;
    cfg_data = '0;
    req_taken = 1'b0;
    fault_count = 0;
    send_idle_pct = 13;
    rd_pos = '0;
    seq_head = '0;
    seq_on = 1'b0;
    is_playing = 1'b0;
    ticks_left = '0;
    sample_acc = '0;
    end_word = END_RESET;
    repeat_word = REPEAT_RESET;
    vol_mask = VOL_RESET;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole store so that every read hits a written word
    for (k = 0; k < 256; k++) begin
      if (k == 0) w = '0;
      else if (k == 255) w = '1;
      else if (k % 2 == 0) w = pick_freq();
      else w = pick_duration();
      push_req(ACT_WRITE, ADDR_IN_W'(k), w, SAMPLE_W'($urandom), 1'($urandom));
    end

    // directed sequences under reset markers
    push_req(ACT_WRITE, 8'd250, VOL_RESET | 16'd440, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd251, 16'd3, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd252, 16'd0, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd253, 16'd2, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd254, 16'hFFFF, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd255, 16'd1, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd0, REPEAT_RESET, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd10, REPEAT_RESET, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd11, 16'd5, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd20, 16'd1000, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd21, 16'd0, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd30, 16'd500, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd31, 16'hFFFF, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd40, END_RESET, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd50, 16'd300, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd51, 16'd1, 10'd0, 1'b1);
    push_req(ACT_WRITE, 8'd52, END_RESET, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b1);
    push_req(ACT_STOP, 8'd0, 16'd0, 10'd0, 1'b1);
    push_req(ACT_START, 8'd250, 16'd0, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd44, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd43, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b0);
    push_req(ACT_STOP, 8'd0, 16'd0, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b1);
    push_req(ACT_START, 8'd10, 16'd0, 10'd0, 1'b1);
    push_req(ACT_START, 8'd20, 16'd0, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b1);
    push_req(ACT_START, 8'd30, 16'd0, 10'd0, 1'b0);
    push_req(ACT_AUDIO, 8'd0, 16'd0, 10'd1023, 1'b1);
    push_req(ACT_START, 8'd40, 16'd0, 10'd0, 1'b1);
    push_req(ACT_START, 8'd50, 16'd0, 10'd0, 1'b1);
    push_req(ACT_AUDIO, 8'd255, 16'hFFFF, 10'd1023, 1'b1);

    for (phase = 0; phase < 6; phase++) begin
      if (phase != 0) begin
        while (player_requests.size() != 0 || note_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        case (phase)
          1: begin
            cfg_vals[REG_END_MARKER] = 16'h0000;
            cfg_vals[REG_REPEAT_MARKER] = 16'hFFFF;
            cfg_vals[REG_VOLUME_MASK] = 16'h0000;
          end
          2: begin
            cfg_vals[REG_END_MARKER] = 16'hFFFF;
            cfg_vals[REG_REPEAT_MARKER] = 16'h0000;
            cfg_vals[REG_VOLUME_MASK] = 16'hFFFF;
          end
          3: begin
            cfg_vals[REG_END_MARKER] = WORD_W'($urandom);
            cfg_vals[REG_REPEAT_MARKER] = cfg_vals[REG_END_MARKER] ^
                                          (16'h1 << $urandom_range(15));
            cfg_vals[REG_VOLUME_MASK] = WORD_W'($urandom);
          end
          4: begin
            cfg_vals[REG_END_MARKER] = END_RESET;
            cfg_vals[REG_REPEAT_MARKER] = REPEAT_RESET;
            cfg_vals[REG_VOLUME_MASK] = VOL_RESET;
          end
          default: begin
            cfg_vals[REG_END_MARKER] = 16'h7FFF;
            cfg_vals[REG_REPEAT_MARKER] = 16'h7FFE;
            cfg_vals[REG_VOLUME_MASK] = 16'hC000;
          end
        endcase
        for (k = 0; k < 3; k++) begin
          @(negedge clk);
          cfg_we <= 1'b1;
          cfg_index <= cfg_reg_t'(k);
          cfg_data <= cfg_vals[k];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        end_word = cfg_vals[REG_END_MARKER];
        repeat_word = cfg_vals[REG_REPEAT_MARKER];
        vol_mask = cfg_vals[REG_VOLUME_MASK];
      end
      send_idle_pct = phase < 2 ? 13 : (phase < 4 ? 88 : 0);

      // tone program: segments ending in an end or a repeat marker
      heads.delete();
      wp = ADDR_IN_W'($urandom);
      for (seg = 0; seg < 5; seg++) begin
        heads.push_back(wp);
        tones = $urandom_range(5, 1);
        for (k = 0; k < tones; k++) begin
          w = (k == 0 && $urandom_range(9) == 0) ? repeat_word : pick_freq();
          push_req(ACT_WRITE, wp, w, SAMPLE_W'($urandom), 1'($urandom));
          wp = wp + 1'b1;
          push_req(ACT_WRITE, wp, pick_duration(), SAMPLE_W'($urandom), 1'($urandom));
          wp = wp + 1'b1;
        end
        w = $urandom_range(99) < 55 ? end_word : repeat_word;
        push_req(ACT_WRITE, wp, w, SAMPLE_W'($urandom), 1'($urandom));
        wp = wp + 1'b1;
      end

      for (n = 0; n < 240; n++) begin
        r = $urandom_range(99);
        snd = $urandom_range(9) != 0;
        if (r < 60) begin
          k = $urandom_range(9);
          push_req(ACT_AUDIO, ADDR_IN_W'($urandom), WORD_W'($urandom),
                   k < 2 ? 10'd1023 : (k < 3 ? SAMPLE_W'($urandom_range(60))
                                             : SAMPLE_W'($urandom)), snd);
        end else if (r < 75) begin
          push_req(ACT_START, $urandom_range(5) != 0 ? heads[$urandom_range(heads.size() - 1)]
                                                     : ADDR_IN_W'($urandom),
                   WORD_W'($urandom), SAMPLE_W'($urandom), snd);
        end else if (r < 80) begin
          push_req(ACT_STOP, ADDR_IN_W'($urandom), WORD_W'($urandom), SAMPLE_W'($urandom), snd);
        end else if (r < 90) begin
          push_req(ACT_WRITE, ADDR_IN_W'($urandom),
                   $urandom_range(1) ? pick_freq() : pick_duration(), SAMPLE_W'($urandom), snd);
        end else begin
          push_req(action_t'($urandom_range(3)), ADDR_IN_W'($urandom), WORD_W'($urandom),
                   SAMPLE_W'($urandom), 1'($urandom));
        end
      end
    end

    while (player_requests.size() != 0 || note_reports.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
